// ----- design/wildcard_glob_matcher_top_assert.svh -----
// Assertion macros for the wildcard glob matcher.
// Included by the top level; no other dependencies.
`ifndef WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WGM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WGM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wgm_pkg.sv -----
// Shared types and constants for the wildcard glob matcher.
// No dependencies.
package wgm_pkg;

  localparam int unsigned PATTERN_LEN_DEF = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
  localparam logic [CHAR_W-1:0] EOS_CHAR  = 8'h00;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_NAME = 1'b1
  } req_type_t;

  // Broadcast from the top to every cell.
  typedef struct packed {
    logic              upd;      // item accepted this cycle
    logic              load;     // pattern character write
    logic              rearm;    // restart from position 0 (load or end of name)
    logic              len_set;  // pattern terminator at a legal position
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_ctl_t;

  // Handed from a cell to its right neighbor.
  typedef struct packed {
    logic hit;    // position advanced past a matching char
    logic carry;  // star closure ripple
  } cell_link_t;

  // Cell state seen by the top.
  typedef struct packed {
    logic act;
    logic en;
    logic at_end;
  } cell_stat_t;

endpackage

// ----- design/wgm_in_if.sv -----
// Input channel of the wildcard glob matcher.
// Depends on wgm_pkg.
interface wgm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [wgm_pkg::POS_W-1:0]  position;
  logic [wgm_pkg::CHAR_W-1:0] char_value;

  modport source (output valid, req_type, position, char_value, input ready);
  modport sink   (input valid, req_type, position, char_value, output ready);
endinterface

// ----- design/wgm_out_if.sv -----
// Result channel of the wildcard glob matcher.
// No dependencies.
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

// ----- design/wgm_cell.sv -----
// One pattern position: stored char, in-pattern flag, end flag, active bit.
// Depends on wgm_pkg.
module wgm_cell #(
  parameter int unsigned PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF,
  parameter int unsigned IDX         = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wgm_pkg::cell_ctl_t  ctl,
  input  wgm_pkg::cell_link_t link_in,
  output wgm_pkg::cell_link_t link_out,
  output wgm_pkg::cell_stat_t stat
);

  localparam int unsigned LEN_W = $clog2(PATTERN_LEN + 1);
  localparam int unsigned CMP_W = (LEN_W > wgm_pkg::POS_W) ? LEN_W : wgm_pkg::POS_W;
  localparam logic        IS_FIRST = (IDX == 0);

  logic [wgm_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                       en_r, en_nxt;
  logic                       at_end_r, at_end_nxt;
  logic                       act_r, act_nxt;
  logic [CMP_W-1:0]           pos_ext, idx_ext;
  logic                       star_r, star_nxt, keep, hit, raw;

  assign pos_ext = CMP_W'(ctl.pos);
  assign idx_ext = CMP_W'(IDX);
  assign star_r  = (char_r == wgm_pkg::STAR_CHAR);

  always_comb begin
    char_nxt   = char_r;
    en_nxt     = en_r;
    at_end_nxt = at_end_r;
    if (ctl.load && (pos_ext == idx_ext)) begin
      char_nxt = ctl.ch;
    end
    if (ctl.len_set) begin
      en_nxt     = (idx_ext < pos_ext);
      at_end_nxt = (idx_ext == pos_ext);
    end
    star_nxt = (char_nxt == wgm_pkg::STAR_CHAR);

    // star stays put, anything else advances on a match
    keep = act_r & en_r & star_r;
    hit  = act_r & en_r & ~star_r &
           ((char_r == wgm_pkg::ANY_CHAR) || (char_r == ctl.ch));
    raw  = ctl.rearm ? IS_FIRST : (keep | link_in.hit);

    act_nxt        = raw | link_in.carry;
    link_out.hit   = ~ctl.rearm & hit;
    link_out.carry = act_nxt & en_nxt & star_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= IS_FIRST;
      en_r     <= 1'b0;
      at_end_r <= IS_FIRST;
    end else if (ctl.upd) begin
      act_r    <= act_nxt;
      en_r     <= en_nxt;
      at_end_r <= at_end_nxt;
    end
  end

  // pattern byte, undefined until written
  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      char_r <= char_nxt;
    end
  end

  assign stat.act    = act_r;
  assign stat.en     = en_r;
  assign stat.at_end = at_end_r;

endmodule

// ----- design/wildcard_glob_matcher_top.sv -----
// Wildcard glob matcher: a row of PATTERN_LEN position cells plus a tail bit.
// Throughput: one item (load or name byte) per cycle while the result slot is free or drained.
// The match flag is registered and shows in the cycle after the end-of-name item is accepted.
// Critical path: the star closure ripple across the cell row, one AND-OR per cell.
// Reset: pattern length zero (empty pattern), matcher armed at position 0, no result
// pending; pattern bytes are undefined until loaded, with no clearing pass.
module wildcard_glob_matcher_top #(
  parameter int unsigned PATTERN_LEN = wgm_pkg::PATTERN_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  wgm_in_if.sink   in_ch,
  wgm_out_if.source out_ch
);

  localparam int unsigned LEN_W = $clog2(PATTERN_LEN + 1);
  localparam int unsigned CMP_W = (LEN_W > wgm_pkg::POS_W) ? LEN_W : wgm_pkg::POS_W;

  wgm_pkg::cell_ctl_t  ctl;
  wgm_pkg::cell_link_t link [PATTERN_LEN+1];
  wgm_pkg::cell_stat_t stat [PATTERN_LEN];

  logic [PATTERN_LEN:0] act_vec, en_vec, end_vec;

  logic in_ready, acc, is_name, eos;
  logic [CMP_W-1:0] pos_ext;

  logic act_tail_r, act_tail_nxt;
  logic end_tail_r, end_tail_nxt;
  logic out_valid_r, out_valid_nxt;
  logic matched_r;
  logic match_now;

  // Output register parts the two sides: accept whenever the result slot is
  // free or is being drained this cycle.
  assign in_ready    = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid & in_ready;
  assign is_name     = (in_ch.req_type == wgm_pkg::REQ_NAME);
  assign eos         = is_name & (in_ch.char_value == wgm_pkg::EOS_CHAR);
  assign pos_ext     = CMP_W'(in_ch.position);

  // Control broadcast; a load or an end-of-name item re-arms the row.
  always_comb begin
    ctl.upd     = acc;
    ctl.load    = acc & ~is_name;
    ctl.rearm   = ~is_name | eos;
    ctl.len_set = acc & ~is_name & (in_ch.char_value == wgm_pkg::EOS_CHAR) &
                  (pos_ext <= CMP_W'(PATTERN_LEN));
    ctl.pos     = in_ch.position;
    ctl.ch      = in_ch.char_value;
  end

  assign link[0] = '0;

  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    wgm_cell #(
      .PATTERN_LEN (PATTERN_LEN),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat[i])
    );
    assign act_vec[i] = stat[i].act;
    assign en_vec[i]  = stat[i].en;
    assign end_vec[i] = stat[i].at_end;
  end

  // Tail position: a pattern filling the whole store ends here.
  assign act_tail_nxt = link[PATTERN_LEN].hit | link[PATTERN_LEN].carry;
  assign end_tail_nxt = ctl.len_set ? (pos_ext == CMP_W'(PATTERN_LEN)) : end_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_tail_r <= 1'b0;
      end_tail_r <= 1'b0;
    end else if (acc) begin
      act_tail_r <= act_tail_nxt;
      end_tail_r <= end_tail_nxt;
    end
  end

  assign act_vec[PATTERN_LEN] = act_tail_r;
  assign en_vec[PATTERN_LEN]  = 1'b0;
  assign end_vec[PATTERN_LEN] = end_tail_r;

  // Name matches when the position at the pattern end is still alive.
  assign match_now = |(act_vec & end_vec);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc && eos) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && eos) begin
      matched_r <= match_now;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = matched_r;

  `include "wildcard_glob_matcher_top_assert.svh"

  `WGM_ASSERT_NXT(a_eos_gives_item, clk, rst_n, acc && eos, out_valid_r, "end of name lost")
  `WGM_ASSERT_NXT(a_rearm_start, clk, rst_n, acc && ctl.rearm, act_vec[0], "rearm missed start")
  `WGM_ASSERT_IMP(a_one_end, clk, rst_n, 1'b1, $onehot(end_vec), "pattern end not unique")
  `WGM_ASSERT_IMP(a_no_act_past_end, clk, rst_n, 1'b1, (act_vec & ~(en_vec | end_vec)) == '0,
                  "active position beyond pattern end")

endmodule
